[hdl/bwf_pkg.sv]
// Shared types, constants and helper functions for the boson wavefunction force block.
package bwf_pkg;

  localparam int MAX_PARTICLES = 32;
  localparam int COORD_W       = 32;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
  localparam int ADDR_W        = IDX_W + 1;
  localparam int POS_W         = 3 * COORD_W;

  localparam logic [1:0] REG_ALPHA_XY    = 2'd0;
  localparam logic [1:0] REG_ALPHA_Z     = 2'd1;
  localparam logic [1:0] REG_CORE_RADIUS = 2'd2;
  localparam logic [1:0] REG_NUM_DIMS    = 2'd3;

  // multiply-divide unit: true divide, or product scaled down by a fixed shift
  typedef enum logic [1:0] {MD_DIV, MD_SHR16, MD_SHR30} md_mode_t;

  localparam logic [63:0] ONE_Q30   = 64'h0000_0000_4000_0000;
  localparam logic [63:0] HALF_Q30  = 64'h0000_0000_2000_0000;
  localparam logic [63:0] LOG2E_Q30 = 64'd1549082005;
  localparam logic [63:0] TERM_CAP  = 64'h0100_0000_0000_0000;
  localparam logic [63:0] ONE_Q16   = 64'h0000_0000_0001_0000;
  localparam logic [63:0] TWO_Q16   = 64'h0000_0000_0002_0000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_particle;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         particle_index;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [30:0]        amplitude;
    logic               overlap;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    logic [31:0] alpha_xy;
    logic [31:0] alpha_z;
    logic [31:0] core_radius;
    logic [1:0]  num_dims;
  } cfg_t;

  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [POS_W-1:0]  data;
  } store_wr_t;

  function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[64] ? '1 : s[63:0];
  endfunction

  // 2^(-2^-(i+1)) in Q0.30
  function automatic logic [29:0] pow2_frac(input logic [3:0] idx);
    logic [29:0] v;
    unique case (idx)
      4'd0:  v = 30'd759250125;
      4'd1:  v = 30'd902905651;
      4'd2:  v = 30'd984625594;
      4'd3:  v = 30'd1028218693;
      4'd4:  v = 30'd1050733751;
      4'd5:  v = 30'd1062109164;
      4'd6:  v = 30'd1067911080;
      4'd7:  v = 30'd1070838486;
      4'd8:  v = 30'd1072289173;
      4'd9:  v = 30'd1073015252;
      4'd10: v = 30'd1073378477;
      4'd11: v = 30'd1073560135;
      4'd12: v = 30'd1073650976;
      4'd13: v = 30'd1073696399;
      4'd14: v = 30'd1073719111;
      4'd15: v = 30'd1073730468;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [COORD_W-1:0] coord_sel(input logic [POS_W-1:0] p,
                                                          input logic [1:0] d);
    logic signed [COORD_W-1:0] c;
    unique case (d)
      2'd0:    c = p[0 +: COORD_W];
      2'd1:    c = p[COORD_W +: COORD_W];
      2'd2:    c = p[2*COORD_W +: COORD_W];
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

[hdl/bwf_front.sv]
// Input side: takes position transfers, fills the store and queues evaluation jobs.
module bwf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bwf_pkg::in_item_t  in_data,
  output bwf_pkg::store_wr_t store_wr,
  output logic               job_push,
  output bwf_pkg::job_t      job,
  input  logic               job_done
);
  import bwf_pkg::*;

  logic [CNT_W-1:0] count;
  logic             bank;
  logic [1:0]       pending;
  logic [1:0]       pending_next;
  logic             xfer;
  logic             room;

  // two banks: a job holds its bank until its last result is out
  assign in_ready = (pending != 2'd2);
  assign xfer     = in_valid && in_ready;
  assign room     = (count < CNT_W'(MAX_PARTICLES));
  assign job_push = xfer && in_data.last_particle;

  always_comb begin
    store_wr.we   = xfer && room;
    store_wr.addr = {bank, count[IDX_W-1:0]};
    store_wr.data = {in_data.pos_z[COORD_W-1:0], in_data.pos_y[COORD_W-1:0],
                     in_data.pos_x[COORD_W-1:0]};
    job.bank      = bank;
    job.count     = room ? count + CNT_W'(1) : count;
    pending_next  = pending + {1'b0, job_push} - {1'b0, job_done};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      bank    <= 1'b0;
      pending <= 2'd0;
    end else begin
      pending <= pending_next;
      if (xfer) begin
        if (in_data.last_particle) begin
          count <= '0;
          bank  <= ~bank;
        end else if (room) begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  a_pending_max: assert property (@(posedge clk) disable iff (rst) pending != 2'd3)
    else $error("more jobs outstanding than store banks");
  a_done_owned: assert property (@(posedge clk) disable iff (rst)
    job_done |-> pending != 2'd0)
    else $error("job finished with none outstanding");

endmodule

[hdl/bwf_jobq.sv]
// Two-entry job queue between the input side and the evaluation engine.
module bwf_jobq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bwf_pkg::job_t din,
  input  logic          pop,
  output bwf_pkg::job_t dout,
  output logic          not_empty
);
  import bwf_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign not_empty = (fill != 2'd0);
  assign dout      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (fill != 2'd2) || pop)
    else $error("job queue overflow");

endmodule

[hdl/bwf_muldiv.sv]
// Shared bit-serial unit: floor(a*b/c), or a*b shifted right by 16 or 30, on 64-bit magnitudes, saturating.
module bwf_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  bwf_pkg::md_mode_t mode,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  input  logic [63:0]       c,
  output logic [63:0]       q,
  output logic              done
);
  import bwf_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_CHK, M_DIV} mstate_t;

  mstate_t      state;
  md_mode_t     mreg;
  logic [5:0]   cnt;
  logic [63:0]  areg;
  logic [63:0]  breg;
  logic [63:0]  creg;
  logic [63:0]  hi;
  logic [63:0]  lo;
  logic [127:0] acc_next;
  logic [63:0]  hs;
  logic         take;

  always_comb begin
    acc_next = {hi[62:0], lo, 1'b0} + (breg[63] ? {64'b0, areg} : 128'b0);
    hs       = {hi[62:0], lo[63]};
    take     = hi[63] || (hs >= creg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (go) begin
            areg  <= a;
            breg  <= b;
            creg  <= c;
            mreg  <= mode;
            hi    <= '0;
            lo    <= '0;
            cnt   <= '0;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          {hi, lo} <= acc_next;
          breg     <= {breg[62:0], 1'b0};
          cnt      <= cnt + 6'd1;
          if (cnt == 6'd63) state <= M_CHK;
        end
        M_CHK: begin
          unique case (mreg)
            MD_SHR16: begin
              q     <= (hi[63:16] != 48'd0) ? '1 : {hi[15:0], lo[63:16]};
              done  <= 1'b1;
              state <= M_IDLE;
            end
            MD_SHR30: begin
              q     <= (hi[63:30] != 34'd0) ? '1 : {hi[29:0], lo[63:30]};
              done  <= 1'b1;
              state <= M_IDLE;
            end
            default: begin
              if (creg == 64'd0 || hi >= creg) begin
                q     <= '1;
                done  <= 1'b1;
                state <= M_IDLE;
              end else begin
                q     <= '0;
                cnt   <= '0;
                state <= M_DIV;
              end
            end
          endcase
        end
        M_DIV: begin
          hi  <= take ? hs - creg : hs;
          lo  <= {lo[62:0], 1'b0};
          q   <= {q[62:0], take};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            done  <= 1'b1;
            state <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

[hdl/bwf_isqrt.sv]
// Iterative integer square root of a 64-bit value, two bits per cycle.
module bwf_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] v,
  output logic [31:0] root,
  output logic        done
);
  import bwf_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitm;
  logic [63:0] trial;

  assign trial = res + bitm;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (go) begin
          rem  <= v;
          res  <= '0;
          bitm <= 64'h4000_0000_0000_0000;
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= {1'b0, res[63:1]} + bitm;
        end else begin
          res <= {1'b0, res[63:1]};
        end
        bitm <= {2'b0, bitm[63:2]};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/bwf_back.sv]
// Evaluation engine: position store, amplitude and force sequencer, result register.
module bwf_back (
  input  logic                clk,
  input  logic                rst,
  input  bwf_pkg::cfg_t       cfg,
  input  bwf_pkg::store_wr_t  store_wr,
  input  logic                job_valid,
  input  bwf_pkg::job_t       job,
  output logic                job_pop,
  output logic                job_done,
  output logic                out_valid,
  input  logic                out_ready,
  output bwf_pkg::out_item_t  out_data
);
  import bwf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_FETCH, S_WAIT, S_PD_SQ, S_PD_ACC,
    S_A_I, S_A_EXPSQ, S_A_EXPMD, S_A_EXPACC, S_A_J, S_A_PAIR, S_A_JMUL, S_A_JRND,
    S_E_Y, S_E_CHK, S_E_TAB, S_E_TRND, S_E_SH, S_AMP_MUL, S_AMP_RND,
    S_F_K, S_F_G, S_F_GACC, S_F_J, S_F_PAIR, S_F_T1, S_F_T2, S_F_T3, S_F_TACC,
    S_F_EMIT
  } state_t;

  logic [POS_W-1:0] mem [2*MAX_PARTICLES];
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [POS_W-1:0]  rd_a;
  logic [POS_W-1:0]  rd_b;

  state_t            state;
  state_t            ret_state;
  state_t            pd_ret;
  logic [CNT_W-1:0]  n;
  logic              bank;
  logic [CNT_W-1:0]  i;
  logic [CNT_W-1:0]  j;
  logic [1:0]        d;
  logic [4:0]        t;
  logic [63:0]       expo;
  logic [30:0]       jast;
  logic              ovl;
  logic [30:0]       amp;
  logic [30:0]       m;
  logic [63:0]       y;
  logic [63:0]       prod;
  logic [63:0]       r2;
  logic [31:0]       r;
  logic signed [63:0] acc [3];

  logic        md_go;
  md_mode_t    md_mode;
  logic [63:0] md_a;
  logic [63:0] md_b;
  logic [63:0] md_c;
  logic [63:0] md_q;
  logic        md_done;
  logic        sq_go;
  logic [63:0] sq_in;
  logic [31:0] sq_root;
  logic        sq_done;

  logic [1:0]                dims;
  logic                      d_last;
  logic signed [COORD_W-1:0] xa;
  logic signed [COORD_W-1:0] xb;
  logic [COORD_W:0]          xa_neg;
  logic [COORD_W-1:0]        ax;
  logic signed [COORD_W:0]   dx;
  logic [COORD_W:0]          dx_neg;
  logic [COORD_W-1:0]        adx;
  logic [31:0]               alpha_d;
  logic [63:0]               g;
  logic [63:0]               tcap;
  logic [63:0]               rnd;
  logic [3:0]                tab_bit;
  logic                      out_free;
  logic                      last_i;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] s;
    if (v > 64'sh0000_0000_7FFF_FFFF) s = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) s = 32'sh8000_0000;
    else s = v[31:0];
    return s;
  endfunction

  always_comb begin
    dims     = (cfg.num_dims == 2'd0) ? 2'd1 : cfg.num_dims;
    d_last   = (d == dims - 2'd1);
    xa       = coord_sel(rd_a, d);
    xb       = coord_sel(rd_b, d);
    xa_neg   = -{xa[COORD_W-1], xa};
    ax       = xa[COORD_W-1] ? xa_neg[COORD_W-1:0] : xa;
    dx       = {xa[COORD_W-1], xa} - {xb[COORD_W-1], xb};
    dx_neg   = -dx;
    adx      = dx[COORD_W] ? dx_neg[COORD_W-1:0] : dx[COORD_W-1:0];
    alpha_d  = d[1] ? cfg.alpha_z : cfg.alpha_xy;
    g        = {15'b0, prod[63:16], 1'b0};
    tcap     = (md_q > TERM_CAP) ? TERM_CAP : md_q;
    rnd      = prod + HALF_Q30;
    tab_bit  = 4'd15 - t[3:0];
    out_free = !out_valid || out_ready;
    last_i   = (i + CNT_W'(1) == n);
  end

  assign job_pop = (state == S_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (store_wr.we) mem[store_wr.addr] <= store_wr.data;
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  bwf_muldiv u_md (
    .clk  (clk),
    .rst  (rst),
    .go   (md_go),
    .mode (md_mode),
    .a    (md_a),
    .b    (md_b),
    .c    (md_c),
    .q    (md_q),
    .done (md_done)
  );

  bwf_isqrt u_sq (
    .clk  (clk),
    .rst  (rst),
    .go   (sq_go),
    .v    (sq_in),
    .root (sq_root),
    .done (sq_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      md_go     <= 1'b0;
      sq_go     <= 1'b0;
      job_done  <= 1'b0;
      out_valid <= 1'b0;
      n         <= '0;
      i         <= '0;
    end else begin
      md_go    <= 1'b0;
      sq_go    <= 1'b0;
      job_done <= 1'b0;
      if (out_valid && out_ready && state != S_F_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            n     <= job.count;
            bank  <= job.bank;
            expo  <= '0;
            jast  <= ONE_Q30[30:0];
            ovl   <= 1'b0;
            i     <= '0;
            state <= S_A_I;
          end
        end
        S_FETCH: state <= ret_state;
        S_WAIT: begin
          if (md_done || sq_done) state <= ret_state;
        end
        S_PD_SQ: begin
          prod  <= 64'(adx) * 64'(adx);
          state <= S_PD_ACC;
        end
        S_PD_ACC: begin
          if (d_last) begin
            sq_in     <= sat_add(r2, prod);
            sq_go     <= 1'b1;
            ret_state <= pd_ret;
            state     <= S_WAIT;
          end else begin
            r2    <= sat_add(r2, prod);
            d     <= d + 2'd1;
            state <= S_PD_SQ;
          end
        end
        S_A_I: begin
          addr_a    <= {bank, i[IDX_W-1:0]};
          d         <= 2'd0;
          ret_state <= S_A_EXPSQ;
          state     <= S_FETCH;
        end
        S_A_EXPSQ: begin
          prod  <= 64'(ax) * 64'(ax);
          state <= S_A_EXPMD;
        end
        S_A_EXPMD: begin
          md_a      <= 64'(alpha_d);
          md_b      <= {16'b0, prod[63:16]};
          md_mode   <= MD_SHR16;
          md_go     <= 1'b1;
          ret_state <= S_A_EXPACC;
          state     <= S_WAIT;
        end
        S_A_EXPACC: begin
          expo <= sat_add(expo, md_q);
          if (d_last) begin
            j     <= i + CNT_W'(1);
            state <= S_A_J;
          end else begin
            d     <= d + 2'd1;
            state <= S_A_EXPSQ;
          end
        end
        S_A_J: begin
          if (j == n) begin
            if (last_i) begin
              state <= S_E_Y;
            end else begin
              i     <= i + CNT_W'(1);
              state <= S_A_I;
            end
          end else begin
            addr_b    <= {bank, j[IDX_W-1:0]};
            r2        <= '0;
            d         <= 2'd0;
            pd_ret    <= S_A_PAIR;
            ret_state <= S_PD_SQ;
            state     <= S_FETCH;
          end
        end
        S_A_PAIR: begin
          if (sq_root <= cfg.core_radius) begin
            ovl   <= 1'b1;
            j     <= j + CNT_W'(1);
            state <= S_A_J;
          end else begin
            md_a      <= 64'(cfg.core_radius);
            md_b      <= ONE_Q30;
            md_c      <= 64'(sq_root);
            md_mode   <= MD_DIV;
            md_go     <= 1'b1;
            ret_state <= S_A_JMUL;
            state     <= S_WAIT;
          end
        end
        S_A_JMUL: begin
          prod  <= 64'(jast) * 64'(ONE_Q30[30:0] - md_q[30:0]);
          state <= S_A_JRND;
        end
        S_A_JRND: begin
          jast  <= rnd[60:30];
          j     <= j + CNT_W'(1);
          state <= S_A_J;
        end
        S_E_Y: begin
          md_a      <= expo;
          md_b      <= LOG2E_Q30;
          md_mode   <= MD_SHR30;
          md_go     <= 1'b1;
          ret_state <= S_E_CHK;
          state     <= S_WAIT;
        end
        S_E_CHK: begin
          y <= md_q;
          if (md_q[63:16] >= 48'd31) begin
            m     <= '0;
            state <= S_AMP_MUL;
          end else begin
            m     <= ONE_Q30[30:0];
            t     <= '0;
            state <= S_E_TAB;
          end
        end
        S_E_TAB: begin
          if (t == 5'd16) begin
            state <= S_E_SH;
          end else if (y[tab_bit]) begin
            prod  <= 64'(m) * 64'(pow2_frac(t[3:0]));
            state <= S_E_TRND;
          end else begin
            t <= t + 5'd1;
          end
        end
        S_E_TRND: begin
          m     <= rnd[60:30];
          t     <= t + 5'd1;
          state <= S_E_TAB;
        end
        S_E_SH: begin
          m     <= m >> y[20:16];
          state <= S_AMP_MUL;
        end
        S_AMP_MUL: begin
          prod  <= 64'(m) * 64'(jast);
          state <= S_AMP_RND;
        end
        S_AMP_RND: begin
          amp   <= ovl ? '0 : rnd[60:30];
          i     <= '0;
          state <= S_F_K;
        end
        S_F_K: begin
          addr_a    <= {bank, i[IDX_W-1:0]};
          d         <= 2'd0;
          ret_state <= S_F_G;
          state     <= S_FETCH;
        end
        S_F_G: begin
          prod  <= 64'(alpha_d) * 64'(ax);
          state <= S_F_GACC;
        end
        S_F_GACC: begin
          acc[d] <= (!xa[COORD_W-1] && (xa != '0)) ? -signed'(g) : signed'(g);
          if (d_last) begin
            j     <= '0;
            state <= S_F_J;
          end else begin
            d     <= d + 2'd1;
            state <= S_F_G;
          end
        end
        S_F_J: begin
          if (j == n) begin
            state <= S_F_EMIT;
          end else if (j == i) begin
            j <= j + CNT_W'(1);
          end else begin
            addr_b    <= {bank, j[IDX_W-1:0]};
            r2        <= '0;
            d         <= 2'd0;
            pd_ret    <= S_F_PAIR;
            ret_state <= S_PD_SQ;
            state     <= S_FETCH;
          end
        end
        S_F_PAIR: begin
          r <= sq_root;
          if (sq_root <= cfg.core_radius) begin
            j     <= j + CNT_W'(1);
            state <= S_F_J;
          end else begin
            d     <= 2'd0;
            state <= S_F_T1;
          end
        end
        S_F_T1: begin
          md_a      <= 64'(cfg.core_radius);
          md_b      <= 64'(adx);
          md_c      <= 64'(r);
          md_mode   <= MD_DIV;
          md_go     <= 1'b1;
          ret_state <= S_F_T2;
          state     <= S_WAIT;
        end
        S_F_T2: begin
          md_a      <= md_q;
          md_b      <= ONE_Q16;
          md_c      <= 64'(r);
          md_mode   <= MD_DIV;
          md_go     <= 1'b1;
          ret_state <= S_F_T3;
          state     <= S_WAIT;
        end
        S_F_T3: begin
          md_a      <= md_q;
          md_b      <= TWO_Q16;
          md_c      <= 64'(r) - 64'(cfg.core_radius);
          md_mode   <= MD_DIV;
          md_go     <= 1'b1;
          ret_state <= S_F_TACC;
          state     <= S_WAIT;
        end
        S_F_TACC: begin
          acc[d] <= dx[COORD_W] ? acc[d] - signed'(tcap) : acc[d] + signed'(tcap);
          if (d_last) begin
            j     <= j + CNT_W'(1);
            state <= S_F_J;
          end else begin
            d     <= d + 2'd1;
            state <= S_F_T1;
          end
        end
        S_F_EMIT: begin
          if (out_free) begin
            out_valid               <= 1'b1;
            out_data.particle_index <= 6'(i);
            out_data.force_x        <= sat32(acc[0]);
            out_data.force_y        <= (dims >= 2'd2) ? sat32(acc[1]) : '0;
            out_data.force_z        <= (dims == 2'd3) ? sat32(acc[2]) : '0;
            out_data.amplitude      <= amp;
            out_data.overlap        <= ovl;
            out_data.last_result    <= last_i;
            if (last_i) begin
              job_done <= 1'b1;
              state    <= S_IDLE;
            end else begin
              i     <= i + CNT_W'(1);
              state <= S_F_K;
            end
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(md_done && sq_done))
    else $error("divider and root unit finished together");
  a_go_waits: assert property (@(posedge clk) disable iff (rst)
    (md_go || sq_go) |-> state == S_WAIT)
    else $error("unit started outside the wait state");
  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_F_EMIT) |-> (i < n))
    else $error("result index beyond particle count");

endmodule

[hdl/boson_wavefunction_force.sv]
// Top level: configuration registers and the front end, job queue and evaluation engine.
//
// Usage: positions come in one per transfer on in_valid/in_ready (in_data).
// A transfer with last_particle set closes the set and queues it for
// evaluation; the engine then returns one transfer per particle on
// out_valid/out_ready, in index order, the final one marked last_result.
// Positions beyond 32 per set are dropped. Loading accepts one particle per
// cycle while in_ready is high. Evaluation of n particles in D dimensions is
// serialized on one bit-serial multiply-divide unit and an iterative square
// root unit: first the amplitude over all pairs, then the forces particle by
// particle, each result sent once its forces are done. Two store banks let
// the next set load while one is evaluated; in_ready drops while two sets
// are outstanding. A stalled receiver holds the result register and the
// engine waits behind it. Reset (rst, synchronous) clears the queue and
// counters and restores the register defaults; registers are written on
// cfg_we by cfg_index and cfg_wdata. The user must write them only while
// the block is idle; the block itself does not enforce this.
module boson_wavefunction_force (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bwf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bwf_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import bwf_pkg::*;

  cfg_t      cfg;
  store_wr_t store_wr;
  logic      job_push;
  job_t      job_in;
  job_t      job_head;
  logic      job_pop;
  logic      job_valid;
  logic      job_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha_xy    <= 32'd32768;
      cfg.alpha_z     <= 32'd32768;
      cfg.core_radius <= 32'd282;
      cfg.num_dims    <= 2'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA_XY:    cfg.alpha_xy    <= cfg_wdata;
        REG_ALPHA_Z:     cfg.alpha_z     <= cfg_wdata;
        REG_CORE_RADIUS: cfg.core_radius <= cfg_wdata;
        REG_NUM_DIMS:    cfg.num_dims    <= cfg_wdata[1:0];
        default:         cfg.num_dims    <= cfg.num_dims;
      endcase
    end
  end

  bwf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .store_wr (store_wr),
    .job_push (job_push),
    .job      (job_in),
    .job_done (job_done)
  );

  bwf_jobq u_jobq (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .din       (job_in),
    .pop       (job_pop),
    .dout      (job_head),
    .not_empty (job_valid)
  );

  bwf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .store_wr  (store_wr),
    .job_valid (job_valid),
    .job       (job_head),
    .job_pop   (job_pop),
    .job_done  (job_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
